[sv/bbe_pkg.sv]
`default_nettype none

package bbe_pkg;

   // Instruction codes carried in the opcode field; other codes are no-ops.
   typedef enum logic [3:0] {
      OP_INC      = 4'd0,
      OP_DEC      = 4'd1,
      OP_LEFT     = 4'd2,
      OP_RIGHT    = 4'd3,
      OP_JUMP_Z   = 4'd4,
      OP_JUMP_NZ  = 4'd5,
      OP_PUT      = 4'd6,
      OP_GET      = 4'd7,
      OP_FINISH   = 4'd8
   } opcode_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [7:0]  amount;
      logic [15:0] jump_target;
      logic [7:0]  in_char;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [7:0]  emit_char;
      logic [7:0]  emit_count;
      logic [7:0]  take_count;
      logic        branch_taken;
      logic        halted;
   } rsp_type;

endpackage

`default_nettype wire

[sv/bbe_ram.sv]
`default_nettype none

module bbe_ram #(
   parameter  int WIDTH     = 8,
   parameter  int DEPTH     = 4096,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[sv/brainfuck_bytecode_executor.sv]
// An accepted word reaches rsp_valid through the execute stage and output registers.
// Throughput: one word per cycle unless rsp_stall holds the output; the single tape RAM port
// pair reads at accept and writes back as the word leaves the execute stage, with a forwarding
// register for back-to-back cell hits. Reset: synchronous, active high; then a clearing pass
// writes zero to every tape cell while req_stall stays high.
`default_nettype none

module brainfuck_bytecode_executor #(
   parameter int TAPE_DEPTH = 4096,
   parameter int PC_BITS    = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bbe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bbe_pkg::rsp_type      rsp_data
);

   localparam int HEAD_BITS = $clog2(TAPE_DEPTH);
   localparam logic [HEAD_BITS:0]   DEPTH_W   = (HEAD_BITS + 1)'(TAPE_DEPTH);
   localparam logic [HEAD_BITS-1:0] LAST_ADDR = HEAD_BITS'(TAPE_DEPTH - 1);

   // Reduce a move amount modulo the ring size: at most four restoring steps,
   // since the quotient of an 8-bit amount by a depth of 16 or more fits 4 bits.
   function automatic logic [7:0] amount_mod(input logic [7:0] amt);
      logic [7:0] r;
      int         step;
      r = amt;
      for (int k = 3; k >= 0; k--) begin
         step = TAPE_DEPTH << k;
         if (step <= 255 && 32'(r) >= step) begin
            r = r - 8'(step);
         end
      end
      return r;
   endfunction

   // Architectural state outside the tape
   logic [HEAD_BITS-1:0] head_ff, head_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic                 halt_ff, halt_in;

   // Clearing pass
   logic                 clr_busy_ff, clr_busy_in;
   logic [HEAD_BITS-1:0] clr_addr_ff, clr_addr_in;

   // Execute stage: the word whose cell read is in flight
   logic                 s1_valid_ff, s1_valid_in;
   bbe_pkg::req_type     s1_req_ff;
   logic [HEAD_BITS-1:0] s1_addr_ff;

   // Output register
   logic                 out_valid_ff, out_valid_in;
   bbe_pkg::rsp_type     out_data_ff;

   // Last RAM write, to patch a read that raced it
   logic                 fwd_valid_ff;
   logic [HEAD_BITS-1:0] fwd_addr_ff;
   logic [7:0]           fwd_data_ff;

   // RAM ports
   logic                 ram_we;
   logic [HEAD_BITS-1:0] ram_waddr;
   logic [7:0]           ram_wdata;
   logic [HEAD_BITS-1:0] ram_raddr;
   logic [7:0]           ram_rdata;

   logic                 s1_adv;
   logic                 accept;
   logic                 fwd_hit;
   logic [7:0]           cur_cell;
   logic [7:0]           new_cell;
   logic                 cell_we;
   bbe_pkg::rsp_type     rsp_in;
   logic [HEAD_BITS:0]   move_w;
   logic [HEAD_BITS:0]   head_sum;

   // The execute stage leaves when the output register is free or draining.
   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = clr_busy_ff || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   // Read at the live head; re-read the held word's cell while it waits.
   assign ram_raddr = (s1_valid_ff && !s1_adv) ? s1_addr_ff : head_ff;

   bbe_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Head moves at accept time: it depends on the amount only, never on cell data,
   // so the next word's read address is ready in the following cycle. Moves by words that
   // follow a finish go unseen, since a halted machine reads no cell.
   always_comb begin
      move_w   = (HEAD_BITS + 1)'(amount_mod(req_data.amount));
      head_sum = {1'b0, head_ff};
      head_in  = head_ff;
      if (accept) begin
         unique case (req_data.opcode)
            bbe_pkg::OP_RIGHT: begin
               head_sum = {1'b0, head_ff} + move_w;
               if (head_sum >= DEPTH_W) begin
                  head_sum = head_sum - DEPTH_W;
               end
               head_in = head_sum[HEAD_BITS-1:0];
            end
            bbe_pkg::OP_LEFT: begin
               head_sum = {1'b0, head_ff} - move_w;
               if ({1'b0, head_ff} < move_w) begin
                  head_sum = head_sum + DEPTH_W;
               end
               head_in = head_sum[HEAD_BITS-1:0];
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   // Patch the read when the write of the previous word hit the same cell.
   assign fwd_hit  = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
   assign cur_cell = fwd_hit ? fwd_data_ff : ram_rdata;

   // Execute: modify the cell, pick the next pc and build the result word.
   always_comb begin
      new_cell = cur_cell;
      cell_we  = 1'b0;
      pc_in    = pc_ff + PC_BITS'(2);
      halt_in  = halt_ff;
      rsp_in   = '0;
      if (halt_ff) begin
         // Hold everything once halted.
         pc_in = pc_ff;
      end else begin
         unique case (s1_req_ff.opcode)
            bbe_pkg::OP_INC: begin
               new_cell = cur_cell + s1_req_ff.amount;
               cell_we  = 1'b1;
            end
            bbe_pkg::OP_DEC: begin
               new_cell = cur_cell - s1_req_ff.amount;
               cell_we  = 1'b1;
            end
            bbe_pkg::OP_JUMP_Z: begin
               if (cur_cell == 8'd0) begin
                  pc_in               = PC_BITS'(s1_req_ff.jump_target);
                  rsp_in.branch_taken = 1'b1;
               end
            end
            bbe_pkg::OP_JUMP_NZ: begin
               if (cur_cell != 8'd0) begin
                  pc_in               = PC_BITS'(s1_req_ff.jump_target);
                  rsp_in.branch_taken = 1'b1;
               end
            end
            bbe_pkg::OP_PUT: begin
               rsp_in.emit_char  = cur_cell;
               rsp_in.emit_count = s1_req_ff.amount;
            end
            bbe_pkg::OP_GET: begin
               // A zero-length get leaves the cell alone.
               new_cell          = s1_req_ff.in_char;
               cell_we           = (s1_req_ff.amount != 8'd0);
               rsp_in.take_count = s1_req_ff.amount;
            end
            bbe_pkg::OP_FINISH: begin
               pc_in   = pc_ff + PC_BITS'(1);
               halt_in = 1'b1;
            end
            default: begin
               // Head moves and unused codes only advance the pc here.
               pc_in = pc_ff + PC_BITS'(2);
            end
         endcase
      end
      rsp_in.next_pc = 16'(pc_in);
      rsp_in.halted  = halt_in;
   end

   // RAM write port: the clearing pass owns it until the tape is zeroed.
   always_comb begin
      if (clr_busy_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = 8'd0;
      end else begin
         ram_we    = s1_adv && cell_we;
         ram_waddr = s1_addr_ff;
         ram_wdata = new_cell;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + HEAD_BITS'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && rsp_stall);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         fwd_valid_ff <= ram_we;
         if (s1_adv) begin
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_data;
         s1_addr_ff <= head_ff;
      end
      if (s1_adv) begin
         out_data_ff <= rsp_in;
      end
      fwd_addr_ff <= ram_waddr;
      fwd_data_ff <= ram_wdata;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[sv/bbe_checker.sv]
`default_nettype none

module bbe_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire bbe_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bbe_pkg::rsp_type rsp_data
);

   logic        req_acc;
   logic        rsp_acc;
   logic [2:0]  pending_ff, pending_in;
   logic        halt_seen_ff;
   logic [15:0] pc_seen_ff;
   logic [3:0]  unused_opcode;

   assign req_acc       = req_valid && !req_stall;
   assign rsp_acc       = rsp_valid && !rsp_stall;
   assign unused_opcode = req_data.opcode;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 3'd1;
      end else if (!req_acc && rsp_acc) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         halt_seen_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_acc && rsp_data.halted) begin
            halt_seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc && rsp_data.halted && !halt_seen_ff) begin
         pc_seen_ff <= rsp_data.next_pc;
      end
   end

   // Tape clearing keeps the input side closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during tape clearing");

   // Every result word answers an accepted word.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result word without a pending request");

   // At most the execute stage and the output register hold words.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more words in flight than stages");

   // Once halted, results repeat the held pc and report nothing else.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_seen_ff |-> rsp_data.halted && rsp_data.next_pc == pc_seen_ff
         && rsp_data.emit_count == 8'd0 && rsp_data.take_count == 8'd0
         && !rsp_data.branch_taken && unused_opcode == req_data.opcode)
      else $error("machine left the halted state");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind brainfuck_bytecode_executor bbe_checker u_bbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[dv/tb_brainfuck_bytecode_executor.sv]
`timescale 1ns / 1ps

module tb_brainfuck_bytecode_executor;

   localparam int TAPE_CELLS   = 4096;
   localparam int RANDOM_WORDS = 1600;
   // The tape clearing pass after reset keeps req_stall high while it zeroes every cell,
   // so the idle limit sits well above it.
   localparam int IDLE_LIMIT   = 20000;
   // Results leave through the execute and output registers; give stray words room.
   localparam int DRAIN_CYCLES = 10;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bbe_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   bbe_pkg::rsp_type rsp_data;

   brainfuck_bytecode_executor #(
      .TAPE_DEPTH (TAPE_CELLS),
      .PC_BITS    (16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Instructions waiting to go out, and outcomes waiting to come back.
   bbe_pkg::req_type instr_backlog[$];
   bbe_pkg::rsp_type predicted_outcomes[$];
   int      instr_total;
   int      words_accepted = 0;
   int      mismatch_count = 0;

   // Machine state as the predictor sees it.
   logic [7:0]  tape_model [0:TAPE_CELLS-1];
   logic [11:0] head_pos = '0;
   logic [15:0] pc_model = '0;
   logic        halt_seen = 1'b0;

   // Step the machine by one instruction and return the outcome it should report.
   function automatic bbe_pkg::rsp_type execute_word(bbe_pkg::req_type w);
      bbe_pkg::rsp_type r;
      logic [7:0]       cur_cell;
      r = '0;
      cur_cell = tape_model[head_pos];
      // Once halted, hold all state and report only the frozen pc.
      if (halt_seen) begin
         r.next_pc = pc_model;
         r.halted = 1'b1;
         return r;
      end
      r.next_pc = pc_model + 16'd2;
      case (w.opcode)
         bbe_pkg::OP_INC:   tape_model[head_pos] = cur_cell + w.amount;
         bbe_pkg::OP_DEC:   tape_model[head_pos] = cur_cell - w.amount;
         bbe_pkg::OP_LEFT:  head_pos = head_pos - {4'd0, w.amount};
         bbe_pkg::OP_RIGHT: head_pos = head_pos + {4'd0, w.amount};
         bbe_pkg::OP_JUMP_Z: begin
            if (cur_cell == 8'd0) begin
               r.next_pc = w.jump_target;
               r.branch_taken = 1'b1;
            end
         end
         bbe_pkg::OP_JUMP_NZ: begin
            if (cur_cell != 8'd0) begin
               r.next_pc = w.jump_target;
               r.branch_taken = 1'b1;
            end
         end
         bbe_pkg::OP_PUT: begin
            r.emit_char = cur_cell;
            r.emit_count = w.amount;
         end
         bbe_pkg::OP_GET: begin
            // A zero-length get consumes nothing and leaves the cell alone.
            if (w.amount != 8'd0) tape_model[head_pos] = w.in_char;
            r.take_count = w.amount;
         end
         bbe_pkg::OP_FINISH: begin
            // Finish is a one-byte instruction.
            r.next_pc = pc_model + 16'd1;
            halt_seen = 1'b1;
         end
         default: ;
      endcase
      pc_model = r.next_pc;
      r.halted = halt_seen;
      return r;
   endfunction

   function automatic void queue_word(logic [3:0] op, logic [7:0] amt, logic [15:0] target,
                                      logic [7:0] ch);
      bbe_pkg::req_type w;
      w.opcode = op;
      w.amount = amt;
      w.jump_target = target;
      w.in_char = ch;
      instr_backlog.push_back(w);
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: send words in bursts of random length with random gaps between them.
   // Valid rises only when a gap ends and drops only after acceptance.
   // ---------------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : drive_words
      bbe_pkg::req_type next_word;
      logic             next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_word = req_data;
         // Predict at acceptance so the outcome queue follows the block's order.
         if (req_valid && !req_stall) begin
            predicted_outcomes.push_back(execute_word(req_data));
            words_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (instr_backlog.size() > 0) begin
               next_word = instr_backlog.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // Start a new burst; a quarter of the time run with no gaps at all.
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         // One assignment per step keeps a back-to-back valid high.
         req_valid <= next_valid;
         req_data <= next_word;
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver stall: switch at random among free flow, light, half and heavy stalling.
   // ---------------------------------------------------------------------------------
   int stall_mode = 0;
   int stall_mode_left = 0;

   always @(posedge clock) begin : pace_results
      logic hold;
      case (stall_mode)
         0:       hold = 1'b0;
         1:       hold = ($urandom_range(0, 3) == 0);
         2:       hold = ($urandom_range(0, 1) == 0);
         default: hold = ($urandom_range(0, 7) != 0);
      endcase
      if (stall_mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(30, 200);
      end else begin
         stall_mode_left--;
      end
      rsp_stall <= hold;
   end

   // ---------------------------------------------------------------------------------
   // Monitor: compare every accepted result word with the oldest predicted outcome.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      bbe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outcomes.size() == 0) begin
            $display("%0t: result expected none actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = predicted_outcomes.pop_front();
            check_field("next_pc", want.next_pc, rsp_data.next_pc);
            check_field("emit_char", want.emit_char, rsp_data.emit_char);
            check_field("emit_count", want.emit_count, rsp_data.emit_count);
            check_field("take_count", want.take_count, rsp_data.take_count);
            check_field("branch_taken", want.branch_taken, rsp_data.branch_taken);
            check_field("halted", want.halted, rsp_data.halted);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves on either channel for too long.
   // ---------------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus: directed corners first, then random program fragments, then halt.
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      int         n;
      int         pick;
      logic [3:0] op;
      logic [7:0] amt;

      for (n = 0; n < TAPE_CELLS; n++) tape_model[n] = 8'h00;

      // Branch on the cleared tape: take the zero jump to the top of the pc range,
      // then wrap the pc on the next step.
      queue_word(bbe_pkg::OP_JUMP_Z, 8'h00, 16'hFFFF, 8'h00);
      queue_word(bbe_pkg::OP_INC, 8'hFF, 16'h0000, 8'hFF);
      queue_word(bbe_pkg::OP_PUT, 8'hFF, 16'h5555, 8'h00);
      queue_word(bbe_pkg::OP_JUMP_NZ, 8'hFF, 16'h0000, 8'h00);
      queue_word(bbe_pkg::OP_JUMP_Z, 8'h00, 16'hAAAA, 8'h55);
      // Wrap the cell upward to zero, then downward past zero.
      queue_word(bbe_pkg::OP_INC, 8'h01, 16'hFFFF, 8'h00);
      queue_word(bbe_pkg::OP_JUMP_NZ, 8'h00, 16'h1234, 8'h00);
      queue_word(bbe_pkg::OP_DEC, 8'h01, 16'h0000, 8'h00);
      queue_word(bbe_pkg::OP_DEC, 8'hFF, 16'h0000, 8'h00);
      // Step left off cell zero onto the last cell of the ring.
      queue_word(bbe_pkg::OP_LEFT, 8'h01, 16'h0000, 8'h00);
      // A zero-length get must leave the cell untouched.
      queue_word(bbe_pkg::OP_GET, 8'h00, 16'h0000, 8'hAA);
      queue_word(bbe_pkg::OP_PUT, 8'h00, 16'h0000, 8'h00);
      queue_word(bbe_pkg::OP_GET, 8'hFF, 16'h0000, 8'hFF);
      queue_word(bbe_pkg::OP_PUT, 8'h01, 16'h0000, 8'h00);
      // Step right past the end of the ring, and try zero-length moves.
      queue_word(bbe_pkg::OP_RIGHT, 8'hFF, 16'hFFFF, 8'hFF);
      queue_word(bbe_pkg::OP_RIGHT, 8'h00, 16'h0000, 8'h00);
      queue_word(bbe_pkg::OP_LEFT, 8'h00, 16'h0000, 8'h00);
      queue_word(bbe_pkg::OP_GET, 8'h01, 16'h0000, 8'h00);
      // Unused codes behave as no-ops.
      for (n = bbe_pkg::OP_FINISH + 1; n < 16; n++)
         queue_word(n[3:0], 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)));

      n = 0;
      while (n < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // Load a cell (often with zero), branch on it, then print it.
            queue_word(bbe_pkg::OP_GET, 8'($urandom_range(1, 255)),
                       16'($urandom_range(0, 65535)),
                       ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            queue_word(($urandom_range(0, 1) == 0) ? bbe_pkg::OP_JUMP_Z : bbe_pkg::OP_JUMP_NZ,
                       8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)));
            queue_word(bbe_pkg::OP_PUT, 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            n += 3;
         end else begin
            if (pick < 97) op = 4'($urandom_range(bbe_pkg::OP_INC, bbe_pkg::OP_GET));
            else op = 4'($urandom_range(bbe_pkg::OP_FINISH + 1, 15));
            amt = 8'($urandom_range(0, 255));
            // Keep most head moves short so cells get revisited.
            if ((op == bbe_pkg::OP_LEFT || op == bbe_pkg::OP_RIGHT) &&
                $urandom_range(0, 3) != 0)
               amt = 8'($urandom_range(0, 3));
            queue_word(op, amt, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            n++;
         end
      end

      // Halt the machine, then confirm that everything after it is ignored.
      queue_word(bbe_pkg::OP_FINISH, 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      for (n = 0; n < 8; n++)
         queue_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      queue_word(bbe_pkg::OP_FINISH, 8'h00, 16'h0000, 8'h00);

      instr_total = instr_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < instr_total) @(posedge clock);
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
